>>> sv/motor_feedback_multiturn_tracker_assert.svh
// ----------------------------------------------------------------------------
// motor feedback tracker assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef MOTOR_FEEDBACK_MULTITURN_TRACKER_ASSERT_SVH
`define MOTOR_FEEDBACK_MULTITURN_TRACKER_ASSERT_SVH

`ifndef ASSERT_OFF
// property holds at every edge outside reset
`define MFT_ASSERT_IMPL(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
    else $error("motor feedback tracker assertion failed");
// trigger implies consequence on the next edge
`define MFT_ASSERT_NEXT(lbl, clk_s, rst_s, trig, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) trig |=> cons) \
    else $error("motor feedback tracker assertion failed");
`else
`define MFT_ASSERT_IMPL(lbl, clk_s, rst_s, prop)
`define MFT_ASSERT_NEXT(lbl, clk_s, rst_s, trig, cons)
`endif

`endif

>>> sv/mft_pkg.sv
// ----------------------------------------------------------------------------
// mft_pkg
// Shared constants, register codes and types of the multiturn tracker.
// ----------------------------------------------------------------------------
package mft_pkg;

  localparam int MOTORS_PER_BUS_DEF = 8;
  localparam int SLOT_W             = 4;
  localparam int NUM_SLOTS          = 16;
  localparam int QUEUE_DEPTH        = 2;

  localparam logic [10:0] BASE_ID     = 11'h201;
  localparam logic [10:0] TRACK_FIRST = 11'h205;
  localparam logic [10:0] TRACK_LAST  = 11'h208;

  localparam int                 ENC_SHIFT    = 13;
  localparam logic signed [17:0] ENC_COUNTS_S = 18'sd8192;

  // configuration port
  localparam int CFG_W     = 14;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_HOME   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_HI = 2'd3;

  localparam logic [12:0] HOME_RST   = 13'd2000;
  localparam logic [12:0] WRAP_RST   = 13'd4100;
  localparam logic [13:0] WIN_LO_RST = 14'd12284;  // -4100 in 14 bits
  localparam logic [12:0] WIN_HI_RST = 13'd2300;

  typedef struct packed {
    logic [12:0]        home;
    logic [12:0]        wrap;
    logic signed [13:0] win_lo;
    logic [12:0]        win_hi;
  } mft_cfg_t;

  // one classified frame as it travels from front to back
  typedef struct packed {
    logic               acc;
    logic [SLOT_W-1:0]  slot;
    logic               trk;
    logic signed [15:0] angle;
    logic signed [15:0] speed;
    logic signed [15:0] current;
    logic [7:0]         temp;
  } mft_item_t;

endpackage

>>> sv/mft_front.sv
// ----------------------------------------------------------------------------
// mft_front
// Takes frames from the input channel, maps the id to a slot and marks
// out-of-range and tracked frames before they enter the queue.
// ----------------------------------------------------------------------------
module mft_front
  import mft_pkg::*;
#(
  parameter int MOTORS_PER_BUS = MOTORS_PER_BUS_DEF
) (
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_bus_select,
  input  logic [10:0]        in_frame_id,
  input  logic signed [15:0] in_angle_word,
  input  logic signed [15:0] in_speed_word,
  input  logic signed [15:0] in_current_word,
  input  logic [7:0]         in_temperature,
  input  logic               q_full,
  output logic               push,
  output mft_item_t          push_item
);

  logic              in_range;
  logic              trk;
  logic [10:0]       local_id;
  logic [SLOT_W-1:0] slot;

  always_comb begin
    in_range = (in_frame_id >= BASE_ID) &&
               (in_frame_id < (BASE_ID + 11'(MOTORS_PER_BUS)));
    local_id = in_frame_id - BASE_ID;
    slot     = (in_bus_select ? SLOT_W'(MOTORS_PER_BUS) : '0) + local_id[SLOT_W-1:0];
    trk      = in_range && !in_bus_select &&
               (in_frame_id >= TRACK_FIRST) && (in_frame_id <= TRACK_LAST);
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_item.acc     = in_range;
    push_item.slot    = in_range ? slot : '0;
    push_item.trk     = trk;
    push_item.angle   = in_angle_word;
    push_item.speed   = in_speed_word;
    push_item.current = in_current_word;
    push_item.temp    = in_temperature;
  end

endmodule

>>> sv/mft_queue.sv
// ----------------------------------------------------------------------------
// mft_queue
// Short fifo of classified frames between front and back.
// ----------------------------------------------------------------------------
module mft_queue
  import mft_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  mft_item_t push_item,
  output logic      q_full,
  input  logic      pop,
  output logic      q_valid,
  output mft_item_t q_item
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  mft_item_t        mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign q_full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> sv/mft_back.sv
// ----------------------------------------------------------------------------
// mft_back
// Per-slot state, wrap counting, continuous angle and home offsets, and the
// output register of the result channel.
// ----------------------------------------------------------------------------
`include "motor_feedback_multiturn_tracker_assert.svh"

module mft_back
  import mft_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  mft_cfg_t           cfg,
  input  logic               q_valid,
  input  mft_item_t          q_item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_accepted,
  output logic [3:0]         out_motor_slot,
  output logic signed [15:0] out_angle,
  output logic signed [15:0] out_speed,
  output logic signed [15:0] out_current,
  output logic [7:0]         out_motor_temperature,
  output logic signed [15:0] out_previous_angle,
  output logic signed [15:0] out_turn_count,
  output logic signed [31:0] out_unwrapped_angle,
  output logic signed [16:0] out_return_offset,
  output logic signed [16:0] out_forward_offset,
  output logic signed [16:0] out_start_offset
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_CALC = 1'b1;

  logic state_r, state_nxt;

  // per-slot stores; valid and seen bits stand in for the reset value
  logic [NUM_SLOTS-1:0] slot_valid_r;
  logic [NUM_SLOTS-1:0] slot_seen_r;
  logic signed [15:0]   angle_mem_r [NUM_SLOTS];
  logic signed [15:0]   turns_mem_r [NUM_SLOTS];
  logic signed [31:0]   base_mem_r  [NUM_SLOTS];
  logic signed [16:0]   sd_mem_r    [NUM_SLOTS];

  // item being worked on
  mft_item_t          item_r;
  logic signed [15:0] prev_r;
  logic signed [15:0] turns_r;
  logic signed [31:0] base_r;
  logic               seen_r;
  logic signed [16:0] sd_r;
  logic signed [16:0] d_r;

  logic signed [16:0] home_s;
  logic signed [16:0] d_nxt;
  logic signed [17:0] diff;
  logic signed [17:0] thr;
  logic signed [15:0] turns_upd;
  logic signed [31:0] turns_ext;
  logic signed [31:0] cont;
  logic signed [17:0] d18;
  logic signed [17:0] lo;
  logic signed [17:0] hi;
  logic signed [17:0] ret18;
  logic signed [17:0] fwd18;
  logic signed [16:0] sd_out;
  logic               load;

  logic               out_valid_r;
  logic               out_accepted_r;
  logic [3:0]         out_motor_slot_r;
  logic signed [15:0] out_angle_r;
  logic signed [15:0] out_speed_r;
  logic signed [15:0] out_current_r;
  logic [7:0]         out_temp_r;
  logic signed [15:0] out_prev_r;
  logic signed [15:0] out_turns_r;
  logic signed [31:0] out_cont_r;
  logic signed [16:0] out_ret_r;
  logic signed [16:0] out_fwd_r;
  logic signed [16:0] out_sd_r;

  assign pop  = (state_r == ST_IDLE) && q_valid;
  assign load = (state_r == ST_CALC) && (!out_valid_r || !out_stall);

  always_comb begin
    home_s = {4'b0, cfg.home};
    d_nxt  = home_s - {q_item.angle[15], q_item.angle};
  end

  always_comb begin
    diff = {{2{item_r.angle[15]}}, item_r.angle} - {{2{prev_r[15]}}, prev_r};
    thr  = {5'b0, cfg.wrap};
    if (diff > thr) begin
      turns_upd = turns_r - 16'sd1;
    end else if (diff < -thr) begin
      turns_upd = turns_r + 16'sd1;
    end else begin
      turns_upd = turns_r;
    end
    // base_r reads as zero until the slot has been seen
    turns_ext = {{16{turns_upd[15]}}, turns_upd};
    cont      = (turns_ext <<< ENC_SHIFT) + {{16{item_r.angle[15]}}, item_r.angle} - base_r;
    d18       = {d_r[16], d_r};
    lo        = {{4{cfg.win_lo[13]}}, cfg.win_lo};
    hi        = {5'b0, cfg.win_hi};
    ret18     = ((d18 > lo) && (d18 < hi)) ? d18 : d18 + ENC_COUNTS_S;
    fwd18     = d18[17] ? d18 + ENC_COUNTS_S : d18;
    sd_out    = seen_r ? sd_r : d_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        if (load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      slot_valid_r <= '0;
      slot_seen_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load && item_r.acc) begin
        slot_valid_r[item_r.slot] <= 1'b1;
        if (item_r.trk) begin
          slot_seen_r[item_r.slot] <= 1'b1;
        end
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // read the slot state when the item leaves the queue
  always_ff @(posedge clk) begin
    if (pop) begin
      item_r  <= q_item;
      prev_r  <= slot_valid_r[q_item.slot] ? angle_mem_r[q_item.slot] : '0;
      seen_r  <= slot_seen_r[q_item.slot];
      turns_r <= slot_seen_r[q_item.slot] ? turns_mem_r[q_item.slot] : '0;
      base_r  <= slot_seen_r[q_item.slot] ? base_mem_r[q_item.slot] : '0;
      sd_r    <= slot_seen_r[q_item.slot] ? sd_mem_r[q_item.slot] : '0;
      d_r     <= d_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && item_r.acc) begin
      angle_mem_r[item_r.slot] <= item_r.angle;
      if (item_r.trk) begin
        turns_mem_r[item_r.slot] <= turns_upd;
        if (!seen_r) begin
          base_mem_r[item_r.slot] <= cont;
          sd_mem_r[item_r.slot]   <= d_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_accepted_r   <= item_r.acc;
      out_motor_slot_r <= item_r.acc ? item_r.slot : '0;
      out_angle_r      <= item_r.acc ? item_r.angle : '0;
      out_speed_r      <= item_r.acc ? item_r.speed : '0;
      out_current_r    <= item_r.acc ? item_r.current : '0;
      out_temp_r       <= item_r.acc ? item_r.temp : '0;
      out_prev_r       <= item_r.acc ? prev_r : '0;
      out_turns_r      <= item_r.trk ? turns_upd : '0;
      out_cont_r       <= item_r.trk ? cont : '0;
      out_ret_r        <= item_r.trk ? ret18[16:0] : '0;
      out_fwd_r        <= item_r.trk ? fwd18[16:0] : '0;
      out_sd_r         <= item_r.trk ? sd_out : '0;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_accepted          = out_accepted_r;
  assign out_motor_slot        = out_motor_slot_r;
  assign out_angle             = out_angle_r;
  assign out_speed             = out_speed_r;
  assign out_current           = out_current_r;
  assign out_motor_temperature = out_temp_r;
  assign out_previous_angle    = out_prev_r;
  assign out_turn_count        = out_turns_r;
  assign out_unwrapped_angle   = out_cont_r;
  assign out_return_offset     = out_ret_r;
  assign out_forward_offset    = out_fwd_r;
  assign out_start_offset      = out_sd_r;

  `MFT_ASSERT_IMPL(a_drop_zero, clk, rst_n, (out_valid_r && !out_accepted_r) |-> (out_motor_slot_r == '0 && out_angle_r == '0 && out_cont_r == '0))
  `MFT_ASSERT_NEXT(a_untracked_zero, clk, rst_n, (load && !item_r.trk), (out_turns_r == '0 && out_cont_r == '0 && out_sd_r == '0))
  `MFT_ASSERT_NEXT(a_load_shows, clk, rst_n, load, out_valid_r)
  `MFT_ASSERT_NEXT(a_seen_set, clk, rst_n, (load && item_r.trk), slot_seen_r[$past(item_r.slot)])

endmodule

>>> sv/motor_feedback_multiturn_tracker.sv
// ----------------------------------------------------------------------------
// motor_feedback_multiturn_tracker
// Per-slot motor feedback store with encoder turn tracking on bus 0 ids 0x205 to 0x208.
// ----------------------------------------------------------------------------
// The front end takes a frame every cycle while its two-entry queue has
// room, so short bursts are absorbed at full speed. The back end works one
// frame at a time (read the slot state, then update it and load the output
// register) and takes no new frame from the queue until the current one has
// loaded the output register, which waits while the output stalls. Frames
// whose id is outside the motor range give a result of all zeros and change
// no state. All slot state reads as zero after reset, with no clearing pass;
// configuration writes take effect at once and belong to idle periods.
// ----------------------------------------------------------------------------
module motor_feedback_multiturn_tracker
  import mft_pkg::*;
#(
  parameter int MOTORS_PER_BUS = MOTORS_PER_BUS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_bus_select,
  input  logic [10:0]          in_frame_id,
  input  logic signed [15:0]   in_angle_word,
  input  logic signed [15:0]   in_speed_word,
  input  logic signed [15:0]   in_current_word,
  input  logic [7:0]           in_temperature,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_accepted,
  output logic [3:0]           out_motor_slot,
  output logic signed [15:0]   out_angle,
  output logic signed [15:0]   out_speed,
  output logic signed [15:0]   out_current,
  output logic [7:0]           out_motor_temperature,
  output logic signed [15:0]   out_previous_angle,
  output logic signed [15:0]   out_turn_count,
  output logic signed [31:0]   out_unwrapped_angle,
  output logic signed [16:0]   out_return_offset,
  output logic signed [16:0]   out_forward_offset,
  output logic signed [16:0]   out_start_offset,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  mft_cfg_t  cfg_r;
  logic      q_full;
  logic      push;
  mft_item_t push_item;
  logic      pop;
  logic      q_valid;
  mft_item_t q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.home   <= HOME_RST;
      cfg_r.wrap   <= WRAP_RST;
      cfg_r.win_lo <= WIN_LO_RST;
      cfg_r.win_hi <= WIN_HI_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HOME:   cfg_r.home   <= cfg_wdata[12:0];
        REG_WRAP:   cfg_r.wrap   <= cfg_wdata[12:0];
        REG_WIN_LO: cfg_r.win_lo <= cfg_wdata[13:0];
        REG_WIN_HI: cfg_r.win_hi <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  mft_front #(
    .MOTORS_PER_BUS(MOTORS_PER_BUS)
  ) u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_bus_select   (in_bus_select),
    .in_frame_id     (in_frame_id),
    .in_angle_word   (in_angle_word),
    .in_speed_word   (in_speed_word),
    .in_current_word (in_current_word),
    .in_temperature  (in_temperature),
    .q_full          (q_full),
    .push            (push),
    .push_item       (push_item)
  );

  mft_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  mft_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg                   (cfg_r),
    .q_valid               (q_valid),
    .q_item                (q_item),
    .pop                   (pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_accepted          (out_accepted),
    .out_motor_slot        (out_motor_slot),
    .out_angle             (out_angle),
    .out_speed             (out_speed),
    .out_current           (out_current),
    .out_motor_temperature (out_motor_temperature),
    .out_previous_angle    (out_previous_angle),
    .out_turn_count        (out_turn_count),
    .out_unwrapped_angle   (out_unwrapped_angle),
    .out_return_offset     (out_return_offset),
    .out_forward_offset    (out_forward_offset),
    .out_start_offset      (out_start_offset)
  );

endmodule

>>> bench/motor_feedback_multiturn_tracker_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_feedback_multiturn_tracker_test
// Drives feedback frames through the tracker under several register settings
// and handshake pressure patterns. Every result word is compared against an
// in-bench predictor of the slot stores and the bus 0 encoder turn tracking.
// ----------------------------------------------------------------------------
module motor_feedback_multiturn_tracker_test;
  import mft_pkg::*;

  localparam int ENC_COUNTS = 8192;

  typedef struct {
    logic               bus;
    logic [10:0]        id;
    logic signed [15:0] angle;
    logic signed [15:0] speed;
    logic signed [15:0] current;
    logic [7:0]         temp;
  } frame_t;

  typedef struct {
    logic               accepted;
    logic [3:0]         slot;
    logic signed [15:0] angle;
    logic signed [15:0] speed;
    logic signed [15:0] current;
    logic [7:0]         temp;
    logic signed [15:0] prev_angle;
    logic signed [15:0] turns;
    logic signed [31:0] cont;
    logic signed [16:0] ret;
    logic signed [16:0] fwd;
    logic signed [16:0] start;
  } feedback_t;

  typedef struct {
    frame_t    f;
    bit        fixed_exp;
    feedback_t r;
  } dir_row_t;

  localparam feedback_t NO_FEEDBACK = '{default: '0};

  logic clk;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_bus_select = 1'b0;
  logic [10:0]        in_frame_id = '0;
  logic signed [15:0] in_angle_word = '0;
  logic signed [15:0] in_speed_word = '0;
  logic signed [15:0] in_current_word = '0;
  logic [7:0]         in_temperature = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_accepted;
  logic [3:0]         out_motor_slot;
  logic signed [15:0] out_angle;
  logic signed [15:0] out_speed;
  logic signed [15:0] out_current;
  logic [7:0]         out_motor_temperature;
  logic signed [15:0] out_previous_angle;
  logic signed [15:0] out_turn_count;
  logic signed [31:0] out_unwrapped_angle;
  logic signed [16:0] out_return_offset;
  logic signed [16:0] out_forward_offset;
  logic signed [16:0] out_start_offset;

  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // tracker copy of the registers and slot stores
  logic [12:0]        home_pos = HOME_RST;
  logic [12:0]        wrap_thr = WRAP_RST;
  logic signed [13:0] win_lo = WIN_LO_RST;
  logic [12:0]        win_hi = WIN_HI_RST;

  logic signed [15:0] angle_store[NUM_SLOTS] = '{default: '0};
  logic signed [15:0] prev_store[NUM_SLOTS] = '{default: '0};
  logic signed [15:0] turn_store[NUM_SLOTS] = '{default: '0};
  bit                 tracked_once[NUM_SLOTS] = '{default: 1'b0};
  logic signed [31:0] base_store[NUM_SLOTS] = '{default: '0};
  logic signed [16:0] start_store[NUM_SLOTS] = '{default: '0};

  feedback_t pending_feedback[$];
  dir_row_t  dir_rows[$];
  int        enc_pos[4] = '{default: 0};
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        mismatches = 0;

  motor_feedback_multiturn_tracker dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_bus_select         (in_bus_select),
    .in_frame_id           (in_frame_id),
    .in_angle_word         (in_angle_word),
    .in_speed_word         (in_speed_word),
    .in_current_word       (in_current_word),
    .in_temperature        (in_temperature),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_accepted          (out_accepted),
    .out_motor_slot        (out_motor_slot),
    .out_angle             (out_angle),
    .out_speed             (out_speed),
    .out_current           (out_current),
    .out_motor_temperature (out_motor_temperature),
    .out_previous_angle    (out_previous_angle),
    .out_turn_count        (out_turn_count),
    .out_unwrapped_angle   (out_unwrapped_angle),
    .out_return_offset     (out_return_offset),
    .out_forward_offset    (out_forward_offset),
    .out_start_offset      (out_start_offset),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic frame_t frame_of(int bus, int id, int ang, int spd, int cur, int tmp);
    frame_t f;
    f.bus = 1'(bus);
    f.id = 11'(id);
    f.angle = 16'(ang);
    f.speed = 16'(spd);
    f.current = 16'(cur);
    f.temp = 8'(tmp);
    return f;
  endfunction

  // result of an accepted frame on a slot without tracking
  function automatic feedback_t stored(int slot, int ang, int spd, int cur, int tmp, int prv);
    feedback_t r;
    r = NO_FEEDBACK;
    r.accepted = 1'b1;
    r.slot = 4'(slot);
    r.angle = 16'(ang);
    r.speed = 16'(spd);
    r.current = 16'(cur);
    r.temp = 8'(tmp);
    r.prev_angle = 16'(prv);
    return r;
  endfunction

  function automatic feedback_t track_frame(frame_t f);
    feedback_t r;
    logic [3:0] s;
    int ang, prv, d, diff, thr, ret, fwd;
    logic signed [31:0] cont;
    r = NO_FEEDBACK;
    if (int'(f.id) < int'(BASE_ID) || int'(f.id) >= int'(BASE_ID) + MOTORS_PER_BUS_DEF)
      return r;
    s = 4'(int'(f.bus) * MOTORS_PER_BUS_DEF + int'(f.id) - int'(BASE_ID));
    prev_store[s] = angle_store[s];
    angle_store[s] = f.angle;
    r = stored(s, f.angle, f.speed, f.current, f.temp, prev_store[s]);
    if (f.bus == 1'b0 && f.id >= TRACK_FIRST && f.id <= TRACK_LAST) begin
      ang = f.angle;
      prv = prev_store[s];
      d = int'(home_pos) - ang;
      thr = int'(wrap_thr);
      diff = ang - prv;
      if (diff > thr)
        turn_store[s] = turn_store[s] - 16'sd1;
      else if (diff < -thr)
        turn_store[s] = turn_store[s] + 16'sd1;
      cont = 32'(int'(turn_store[s]) * ENC_COUNTS + ang) - base_store[s];
      // first tracked frame latches the start reference
      if (!tracked_once[s]) begin
        tracked_once[s] = 1'b1;
        base_store[s] = cont;
        start_store[s] = 17'(d);
      end
      ret = (d > int'(win_lo) && d < int'(win_hi)) ? d : d + ENC_COUNTS;
      fwd = (d >= 0) ? d : d + ENC_COUNTS;
      r.turns = turn_store[s];
      r.cont = cont;
      r.ret = 17'(ret);
      r.fwd = 17'(fwd);
      r.start = start_store[s];
    end
    return r;
  endfunction

  function automatic frame_t random_frame();
    frame_t f;
    int pick, k, step;
    f.bus = 1'($urandom_range(1));
    f.id = 11'($urandom);
    f.angle = 16'($urandom);
    f.speed = 16'($urandom);
    f.current = 16'($urandom);
    f.temp = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 60) begin
      // tracked motor turning, encoder position wraps through 8192
      k = $urandom_range(3);
      step = int'($urandom_range(9000)) - 4500;
      enc_pos[k] = (enc_pos[k] + step + 2 * ENC_COUNTS) % ENC_COUNTS;
      f.bus = 1'b0;
      f.id = TRACK_FIRST + 11'(k);
      f.angle = 16'(enc_pos[k]);
    end else if (pick < 80) begin
      f.id = BASE_ID + 11'($urandom_range(MOTORS_PER_BUS_DEF - 1));
    end else if (pick >= 95) begin
      f.bus = 1'b0;
      f.id = TRACK_FIRST + 11'($urandom_range(3));
      case ($urandom_range(3))
        0: f.angle = 16'sh8000;
        1: f.angle = 16'sh7fff;
        2: f.angle = 16'sh0000;
        default: f.angle = 16'shffff;
      endcase
    end
    return f;
  endfunction

  task automatic send_frame(frame_t f, bit fixed_exp, feedback_t fixed_r);
    feedback_t p;
    p = track_frame(f);
    if (fixed_exp)
      pending_feedback.push_back(fixed_r);
    else
      pending_feedback.push_back(p);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_bus_select <= f.bus;
    in_frame_id <= f.id;
    in_angle_word <= f.angle;
    in_speed_word <= f.speed;
    in_current_word <= f.current;
    in_temperature <= f.temp;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_feedback.size() != 0) @(posedge clk);
  endtask

  task automatic load_settings(int home, int wrap, int lo, int hi);
    cfg_we <= 1'b1;
    cfg_index <= REG_HOME;
    cfg_wdata <= 14'(home);
    @(posedge clk);
    cfg_index <= REG_WRAP;
    cfg_wdata <= 14'(wrap);
    @(posedge clk);
    cfg_index <= REG_WIN_LO;
    cfg_wdata <= 14'(lo);
    @(posedge clk);
    cfg_index <= REG_WIN_HI;
    cfg_wdata <= 14'(hi);
    @(posedge clk);
    cfg_we <= 1'b0;
    home_pos = 13'(home);
    wrap_thr = 13'(wrap);
    win_lo = 14'(lo);
    win_hi = 13'(hi);
  endtask

  task automatic compare_field(string name, longint want, longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t ns: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin : check_words
    feedback_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_feedback.size() == 0) begin
        mismatches++;
        $display("%0t ns: result word with nothing expected, slot %0d", $time,
                 out_motor_slot);
      end else begin
        want = pending_feedback.pop_front();
        compare_field("accepted", want.accepted, out_accepted);
        compare_field("motor_slot", want.slot, out_motor_slot);
        compare_field("angle", want.angle, out_angle);
        compare_field("speed", want.speed, out_speed);
        compare_field("current", want.current, out_current);
        compare_field("motor_temperature", want.temp, out_motor_temperature);
        compare_field("previous_angle", want.prev_angle, out_previous_angle);
        compare_field("turn_count", want.turns, out_turn_count);
        compare_field("unwrapped_angle", want.cont, out_unwrapped_angle);
        compare_field("return_offset", want.ret, out_return_offset);
        compare_field("forward_offset", want.fwd, out_forward_offset);
        compare_field("start_offset", want.start, out_start_offset);
      end
    end
  end

  initial begin : stimulus
    feedback_t r;
    int ph, n;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ids outside the motor range give an all-zero word
    dir_rows.push_back('{frame_of(0, 'h000, -32768, -32768, -32768, 0), 1'b1, NO_FEEDBACK});
    dir_rows.push_back('{frame_of(1, 'h7ff, 32767, 32767, 32767, 255), 1'b1, NO_FEEDBACK});
    dir_rows.push_back('{frame_of(0, 'h200, 'h5555, 'h2aaa, -'h5556, 'haa), 1'b1, NO_FEEDBACK});
    dir_rows.push_back('{frame_of(1, 'h209, -'h5556, 'h5555, 'h2aaa, 'h55), 1'b1, NO_FEEDBACK});
    dir_rows.push_back('{frame_of(0, 'h201, 32767, -32768, 32767, 255), 1'b1,
                         stored(0, 32767, -32768, 32767, 255, 0)});
    dir_rows.push_back('{frame_of(1, 'h208, -32768, 32767, -32768, 0), 1'b1,
                         stored(15, -32768, 32767, -32768, 0, 0)});
    r = stored(4, 0, 100, -100, 40, 0);
    r.ret = 17'sd2000;
    r.fwd = 17'sd2000;
    r.start = 17'sd2000;
    dir_rows.push_back('{frame_of(0, 'h205, 0, 100, -100, 40), 1'b1, r});
    dir_rows.push_back('{frame_of(0, 'h201, -1, 0, 0, 1), 1'b1, stored(0, -1, 0, 0, 1, 32767)});
    // wrap down, wrap up, jumps of exactly the threshold
    dir_rows.push_back('{frame_of(0, 'h205, 8191, 1, 2, 3), 1'b0, NO_FEEDBACK});
    dir_rows.push_back('{frame_of(0, 'h205, 0, 4, 5, 6), 1'b0, NO_FEEDBACK});
    dir_rows.push_back('{frame_of(0, 'h205, 4100, 7, 8, 9), 1'b0, NO_FEEDBACK});
    dir_rows.push_back('{frame_of(0, 'h205, 0, 10, 11, 12), 1'b0, NO_FEEDBACK});
    // first tracked frames that already count a wrap
    dir_rows.push_back('{frame_of(0, 'h206, 32767, -5, 6, 70), 1'b0, NO_FEEDBACK});
    dir_rows.push_back('{frame_of(0, 'h206, -32768, 5, -6, 71), 1'b0, NO_FEEDBACK});
    dir_rows.push_back('{frame_of(0, 'h207, 5000, 300, 400, 50), 1'b0, NO_FEEDBACK});
    dir_rows.push_back('{frame_of(0, 'h208, -5000, -300, -400, 51), 1'b0, NO_FEEDBACK});
    // return window edges and forward offset sign
    dir_rows.push_back('{frame_of(0, 'h208, -300, 0, 0, 52), 1'b0, NO_FEEDBACK});
    dir_rows.push_back('{frame_of(0, 'h208, 6100, 0, 0, 53), 1'b0, NO_FEEDBACK});
    dir_rows.push_back('{frame_of(0, 'h208, 6099, 0, 0, 54), 1'b0, NO_FEEDBACK});
    dir_rows.push_back('{frame_of(0, 'h207, 2000, 0, 0, 55), 1'b0, NO_FEEDBACK});
    dir_rows.push_back('{frame_of(0, 'h207, 2001, 0, 0, 56), 1'b0, NO_FEEDBACK});
    // tracked ids on bus 1 only store
    dir_rows.push_back('{frame_of(1, 'h205, 1234, -1, -1, 57), 1'b0, NO_FEEDBACK});
    dir_rows.push_back('{frame_of(1, 'h202, -1, -1, -1, 255), 1'b0, NO_FEEDBACK});
    dir_rows.push_back('{frame_of(0, 'h203, 100, 200, 300, 58), 1'b0, NO_FEEDBACK});
    dir_rows.push_back('{frame_of(0, 'h204, 32767, 32767, 32767, 59), 1'b0, NO_FEEDBACK});

    foreach (dir_rows[i])
      send_frame(dir_rows[i].f, dir_rows[i].fixed_exp, dir_rows[i].r);
    wait_drain();

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        1: load_settings(0, 0, -8191, 8191);
        2: load_settings(8191, 8191, 0, 0);
        4: load_settings(4096, 2048, -2048, 6000);
        6: load_settings(0, 8191, 0, 8191);
        3, 5, 7: load_settings($urandom_range(8191), $urandom_range(8191),
                               -int'($urandom_range(8191)), $urandom_range(8191));
        default: ;
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      for (n = 0; n < 50; n++) begin
        // in phase 2, let the pipeline empty out once mid-phase
        if (ph == 2 && n == 25)
          wait_drain();
        send_frame(random_frame(), 1'b0, NO_FEEDBACK);
      end
      wait_drain();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/mft_pkg.sv
sv/mft_front.sv
sv/mft_queue.sv
sv/mft_back.sv
sv/motor_feedback_multiturn_tracker.sv
bench/motor_feedback_multiturn_tracker_test.sv
